@@ hw/rtl/rob_pkg.sv @@
// ----------------------------------------------------------------------------
// rob_pkg
// Shared widths, register indexes and the side-band word of the ray box test.
// ----------------------------------------------------------------------------
package rob_pkg;

	localparam int DVD_W = 54;
	localparam int DVS_W = 35;
	localparam int LANES = 6;

	typedef enum logic [2:0] {
		CFG_CENTER_XY      = 3'd0,
		CFG_CENTER_Z       = 3'd1,
		CFG_HALF_EXTENT_XY = 3'd2,
		CFG_HALF_EXTENT_Z  = 3'd3,
		CFG_ROT_ROW0       = 3'd4,
		CFG_ROT_ROW1       = 3'd5,
		CFG_ROT_ROW2       = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0]       tn;
		logic [31:0]       tf;
		logic [2:0][36:0]  ol;
		logic [2:0][35:0]  dl;
		logic [2:0][31:0]  org;
		logic [2:0][31:0]  dir;
		logic [2:0][31:0]  h;
		logic [2:0]        qa_neg;
		logic [2:0]        qb_neg;
		logic [2:0]        dl_zero;
		logic              zmiss;
	} side_t;

endpackage

@@ hw/rtl/rob_div.sv @@
// ----------------------------------------------------------------------------
// rob_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing a valid bit and a side-band word.
// ----------------------------------------------------------------------------
module rob_div #(
	parameter int LANES = 6,
	parameter int DW    = 54,
	parameter int VW    = 35,
	parameter int TW    = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [LANES-1:0][DW-1:0]   dvd,
	input  logic [LANES-1:0][VW-1:0]   dvs,
	input  logic [TW-1:0]              in_tag,
	output logic                       out_valid,
	output logic [LANES-1:0][DW-1:0]   quo,
	output logic [TW-1:0]              out_tag
);

	logic [LANES-1:0][DW-1:0] work_s [DW+1];
	logic [LANES-1:0][VW-1:0] rem_s  [DW+1];
	logic [LANES-1:0][VW-1:0] dvs_s  [DW+1];
	logic [TW-1:0]            tag_s  [DW+1];
	logic                     v_s    [DW+1];

	assign work_s[0] = dvd;
	assign rem_s[0]  = '0;
	assign dvs_s[0]  = dvs;
	assign tag_s[0]  = in_tag;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [LANES-1:0][DW-1:0] work_d;
		logic [LANES-1:0][VW-1:0] rem_d;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				logic [VW:0] sh;
				logic        ge;
				sh = {rem_s[k][l], work_s[k][l][DW-1]};
				ge = (sh >= {1'b0, dvs_s[k][l]});
				rem_d[l] = ge ? VW'(sh - {1'b0, dvs_s[k][l]}) : VW'(sh);
				work_d[l] = {work_s[k][l][DW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				work_s[k+1] <= work_d;
				rem_s[k+1]  <= rem_d;
				dvs_s[k+1]  <= dvs_s[k];
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	assign out_valid = v_s[DW];
	assign quo       = work_s[DW];
	assign out_tag   = tag_s[DW];

endmodule

@@ hw/rtl/ray_oriented_box_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_oriented_box_intersect
// Slab test of one ray against one oriented box per clock while m_axis is not stalled.
// ----------------------------------------------------------------------------
// A ray word enters on s_axis (origin, direction and t window, eight 32-bit
// fields). Each accepted word gives exactly one result word on m_axis, in
// order: tuser carries the hit flag and tdata the distance, world normal and
// world hit point; a miss gives all zeros.
// The box is set through the cfg channel, which is always ready; the user must
// write it only while no ray is in flight, as the block does not enforce this.
// The pipeline has 67 register stages, 54 of them the bit-per-stage slab
// dividers. One ray is accepted in every cycle while the output is taken.
// When m_axis is stalled the whole pipeline holds and s_axis_tready falls;
// nothing is dropped or repeated. Reset clears every valid bit and loads the
// unit box with identity rotation.
// ----------------------------------------------------------------------------
module ray_oriented_box_intersect (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_near, t_far
	input  logic [255:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// hit_t, normal_x, normal_y, normal_z, point_x, point_y, point_z, zero pad
	output logic [191:0] m_axis_tdata,
	// hit
	output logic         m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import rob_pkg::*;

	function automatic logic signed [19:0] rot_ent(input logic [59:0] row,
		input logic [1:0] c);
		logic [19:0] e;
		case (c)
			2'd0:    e = row[19:0];
			2'd1:    e = row[39:20];
			default: e = row[59:40];
		endcase
		return $signed(e);
	endfunction

	logic [63:0] center_xy_q, half_extent_xy_q;
	logic [31:0] center_z_q;
	logic [30:0] half_extent_z_q;
	logic [59:0] rot_q [3];
	logic        en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_xy_q      <= '0;
			center_z_q       <= '0;
			half_extent_xy_q <= 64'h0000_8000_0000_8000;
			half_extent_z_q  <= 31'h0000_8000;
			rot_q[0]         <= 60'd262144;
			rot_q[1]         <= 60'd274877906944;
			rot_q[2]         <= 60'd288230376151711744;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CENTER_XY:      center_xy_q      <= cfg_data;
				CFG_CENTER_Z:       center_z_q       <= cfg_data[31:0];
				CFG_HALF_EXTENT_XY: half_extent_xy_q <= cfg_data;
				CFG_HALF_EXTENT_Z:  half_extent_z_q  <= cfg_data[30:0];
				CFG_ROT_ROW0:       rot_q[0]         <= cfg_data[59:0];
				CFG_ROT_ROW1:       rot_q[1]         <= cfg_data[59:0];
				CFG_ROT_ROW2:       rot_q[2]         <= cfg_data[59:0];
				default: ;
			endcase
		end
	end

	logic [31:0] cen [3];
	logic [31:0] hx [3];
	assign cen[0] = center_xy_q[31:0];
	assign cen[1] = center_xy_q[63:32];
	assign cen[2] = center_z_q;
	assign hx[0]  = half_extent_xy_q[31:0];
	assign hx[1]  = half_extent_xy_q[63:32];
	assign hx[2]  = {1'b0, half_extent_z_q};

	// Valid bits of the stages before and after the dividers.
	logic v_s1, v_s2, v_s3, v_s4;
	logic v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic v_div;

	assign en            = !v_s13 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = v_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4} <= '0;
			{v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13} <= '0;
		end else if (en) begin
			v_s1  <= s_axis_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_div;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// Stage 1: input word, origin relative to the box centre.
	logic signed [31:0] org_s1 [3], dir_s1 [3], tn_s1, tf_s1;
	logic signed [32:0] diff_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				org_s1[r]  <= $signed(s_axis_tdata[32*r +: 32]);
				dir_s1[r]  <= $signed(s_axis_tdata[96 + 32*r +: 32]);
				diff_s1[r] <= $signed({s_axis_tdata[32*r + 31], s_axis_tdata[32*r +: 32]})
					- $signed({cen[r][31], cen[r]});
			end
			tn_s1 <= $signed(s_axis_tdata[223:192]);
			tf_s1 <= $signed(s_axis_tdata[255:224]);
		end
	end

	// Stage 2: products with the transposed rotation.
	logic signed [52:0] po_s2 [3][3];
	logic signed [51:0] pd_s2 [3][3];
	logic signed [31:0] org_s2 [3], dir_s2 [3], tn_s2, tf_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int i = 0; i < 3; i++) begin
					po_s2[r][i] <= rot_ent(rot_q[r], 2'(i)) * diff_s1[r];
					pd_s2[r][i] <= rot_ent(rot_q[r], 2'(i)) * dir_s1[r];
				end
			end
			org_s2 <= org_s1;
			dir_s2 <= dir_s1;
			tn_s2  <= tn_s1;
			tf_s2  <= tf_s1;
		end
	end

	// Stage 3: local origin and direction.
	logic signed [36:0] ol_s3 [3];
	logic signed [35:0] dl_s3 [3];
	logic signed [31:0] org_s3 [3], dir_s3 [3], tn_s3, tf_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [54:0] so;
				logic signed [53:0] sd;
				so = 55'(po_s2[0][i]) + 55'(po_s2[1][i]) + 55'(po_s2[2][i]);
				sd = 54'(pd_s2[0][i]) + 54'(pd_s2[1][i]) + 54'(pd_s2[2][i]);
				ol_s3[i] <= so[54:18];
				dl_s3[i] <= sd[53:18];
			end
			org_s3 <= org_s2;
			dir_s3 <= dir_s2;
			tn_s3  <= tn_s2;
			tf_s3  <= tf_s2;
		end
	end

	// Stage 4: slab offsets as unsigned dividends, signs kept aside.
	logic [LANES-1:0][DVD_W-1:0] dvd_s4;
	logic [LANES-1:0][DVS_W-1:0] dvs_s4;
	side_t                       side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [38:0] he, lo, hi, alo, ahi;
				logic signed [35:0] adl;
				logic               zero;
				he   = $signed({7'b0, hx[i]});
				lo   = -he - 39'(ol_s3[i]);
				hi   = he - 39'(ol_s3[i]);
				alo  = lo[38] ? -lo : lo;
				ahi  = hi[38] ? -hi : hi;
				adl  = dl_s3[i][35] ? -dl_s3[i] : dl_s3[i];
				zero = (dl_s3[i] == '0);
				dvd_s4[2*i]   <= {alo[37:0], 16'b0};
				dvd_s4[2*i+1] <= {ahi[37:0], 16'b0};
				dvs_s4[2*i]   <= adl[34:0];
				dvs_s4[2*i+1] <= adl[34:0];
				side_s4.qa_neg[i]  <= lo[38] ^ dl_s3[i][35];
				side_s4.qb_neg[i]  <= hi[38] ^ dl_s3[i][35];
				side_s4.dl_zero[i] <= zero;
				side_s4.ol[i]      <= ol_s3[i];
				side_s4.dl[i]      <= dl_s3[i];
				side_s4.org[i]     <= org_s3[i];
				side_s4.dir[i]     <= dir_s3[i];
				side_s4.h[i]       <= hx[i];
			end
			side_s4.zmiss <= ((dl_s3[0] == '0) && (($signed({7'b0, hx[0]}) + 39'(ol_s3[0]) < 0)
					|| ($signed({7'b0, hx[0]}) - 39'(ol_s3[0]) < 0)))
				|| ((dl_s3[1] == '0) && (($signed({7'b0, hx[1]}) + 39'(ol_s3[1]) < 0)
					|| ($signed({7'b0, hx[1]}) - 39'(ol_s3[1]) < 0)))
				|| ((dl_s3[2] == '0) && (($signed({7'b0, hx[2]}) + 39'(ol_s3[2]) < 0)
					|| ($signed({7'b0, hx[2]}) - 39'(ol_s3[2]) < 0)));
			side_s4.tn <= tn_s3;
			side_s4.tf <= tf_s3;
		end
	end

	logic [LANES-1:0][DVD_W-1:0] quo;
	side_t                       side_d;

	rob_div #(
		.LANES (LANES),
		.DW    (DVD_W),
		.VW    (DVS_W),
		.TW    ($bits(side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.dvd       (dvd_s4),
		.dvs       (dvs_s4),
		.in_tag    (side_s4),
		.out_valid (v_div),
		.quo       (quo),
		.out_tag   (side_d)
	);

	// Stage 5: signed slab entry and exit per axis.
	logic signed [55:0] ta_s5 [3], tb_s5 [3];
	side_t              side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [55:0] qa, qb;
				qa = $signed({2'b0, quo[2*i]});
				qb = $signed({2'b0, quo[2*i+1]});
				qa = side_d.qa_neg[i] ? -qa : qa;
				qb = side_d.qb_neg[i] ? -qb : qb;
				ta_s5[i] <= side_d.dl[i][35] ? qb : qa;
				tb_s5[i] <= side_d.dl[i][35] ? qa : qb;
			end
			side_s5 <= side_d;
		end
	end

	// Stage 6: window narrowed by the three slabs.
	logic signed [55:0] tmin_s6, tmax_s6;
	side_t              side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [55:0] mn, mx;
			mn = 56'($signed(side_s5.tn));
			mx = 56'($signed(side_s5.tf));
			for (int i = 0; i < 3; i++) begin
				if (!side_s5.dl_zero[i] && ta_s5[i] > mn) mn = ta_s5[i];
				if (!side_s5.dl_zero[i] && tb_s5[i] < mx) mx = tb_s5[i];
			end
			tmin_s6 <= mn;
			tmax_s6 <= mx;
			side_s6 <= side_s5;
		end
	end

	// Stage 7: hit decision and reported distance.
	logic               hit_s7;
	logic signed [31:0] t_s7;
	side_t              side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [55:0] tn, tf;
			logic               ok_min, ok_max, miss;
			tn     = 56'($signed(side_s6.tn));
			tf     = 56'($signed(side_s6.tf));
			miss   = side_s6.zmiss || (tmin_s6 > tmax_s6);
			ok_min = (tmin_s6 > tn) && (tmin_s6 < tf);
			ok_max = (tmax_s6 > tn) && (tmax_s6 < tf);
			hit_s7  <= !miss && (ok_min || ok_max);
			t_s7    <= ok_min ? tmin_s6[31:0] : tmax_s6[31:0];
			side_s7 <= side_s6;
		end
	end

	// Stage 8: distance times local and world direction.
	logic [66:0]        mm_s8 [3];
	logic               neg_s8 [3];
	logic signed [63:0] pw_s8 [3];
	logic               hit_s8;
	logic signed [31:0] t_s8;
	side_t              side_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			logic [31:0] at;
			at = t_s7[31] ? 32'(-t_s7) : 32'(t_s7);
			for (int i = 0; i < 3; i++) begin
				logic signed [35:0] adl;
				adl = side_s7.dl[i][35] ? -$signed(side_s7.dl[i]) : $signed(side_s7.dl[i]);
				mm_s8[i]  <= 67'(at) * 67'(adl[34:0]);
				neg_s8[i] <= t_s7[31] ^ side_s7.dl[i][35];
				pw_s8[i]  <= 64'(t_s7) * 64'($signed(side_s7.dir[i]));
			end
			hit_s8  <= hit_s7;
			t_s8    <= t_s7;
			side_s8 <= side_s7;
		end
	end

	// Stage 9: scaled local offsets with saturation, world hit point.
	logic signed [47:0] ms_s9 [3];
	logic signed [31:0] pt_s9 [3];
	logic               hit_s9;
	logic signed [31:0] t_s9;
	side_t              side_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [63:0] sv;
				logic signed [48:0] ws;
				sv = $signed({1'b0, mm_s8[i][62:0]});
				sv = neg_s8[i] ? -sv : sv;
				if (mm_s8[i] > (67'd1 << 62))
					ms_s9[i] <= neg_s8[i] ? -48'sd70368744177664 : 48'sd70368744177664;
				else
					ms_s9[i] <= sv[63:16];
				ws = 49'($signed(pw_s8[i][63:16])) + 49'($signed(side_s8.org[i]));
				if (ws > 49'sd2147483647)
					pt_s9[i] <= 32'sh7fffffff;
				else if (ws < -49'sd2147483648)
					pt_s9[i] <= 32'sh80000000;
				else
					pt_s9[i] <= ws[31:0];
			end
			hit_s9  <= hit_s8;
			t_s9    <= t_s8;
			side_s9 <= side_s8;
		end
	end

	// Stage 10: local hit point.
	logic signed [48:0] p_s10 [3];
	logic signed [31:0] pt_s10 [3];
	logic               hit_s10;
	logic signed [31:0] t_s10;
	logic [2:0][31:0]   h_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				p_s10[i] <= 49'($signed(side_s9.ol[i])) + 49'(ms_s9[i]);
			pt_s10  <= pt_s9;
			hit_s10 <= hit_s9;
			t_s10   <= t_s9;
			h_s10   <= side_s9.h;
		end
	end

	// Stage 11: distance of the local hit point to each face.
	logic [49:0]        bd_s11 [6];
	logic signed [31:0] pt_s11 [3];
	logic               hit_s11;
	logic signed [31:0] t_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [49:0] he, bl, bh;
				he = $signed({18'b0, h_s10[i]});
				bl = -he - 50'(p_s10[i]);
				bh = he - 50'(p_s10[i]);
				bd_s11[2*i]   <= bl[49] ? 50'(-bl) : 50'(bl);
				bd_s11[2*i+1] <= bh[49] ? 50'(-bh) : 50'(bh);
			end
			pt_s11  <= pt_s10;
			hit_s11 <= hit_s10;
			t_s11   <= t_s10;
		end
	end

	// Stage 12: nearest face, earlier face on a tie.
	logic [2:0]         face_s12;
	logic signed [31:0] pt_s12 [3];
	logic               hit_s12;
	logic signed [31:0] t_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			logic [49:0] best;
			logic [2:0]  f;
			best = bd_s11[0];
			f    = 3'd0;
			for (int j = 1; j < 6; j++) begin
				if (bd_s11[j] < best) begin
					best = bd_s11[j];
					f    = 3'(j);
				end
			end
			face_s12 <= f;
			pt_s12   <= pt_s11;
			hit_s12  <= hit_s11;
			t_s12    <= t_s11;
		end
	end

	// Stage 13: world normal and output register.
	always_ff @(posedge clk) begin
		if (en) begin
			logic [19:0] n [3];
			for (int r = 0; r < 3; r++) begin
				logic signed [19:0] e;
				e = rot_ent(rot_q[r], face_s12[2:1]);
				if (face_s12[0])
					n[r] = e;
				else if (e == -20'sd524288)
					n[r] = 20'h7ffff;
				else
					n[r] = 20'(-e);
			end
			m_axis_tuser <= hit_s12;
			if (hit_s12)
				m_axis_tdata <= {4'b0, pt_s12[2], pt_s12[1], pt_s12[0],
					n[2], n[1], n[0], t_s12};
			else
				m_axis_tdata <= '0;
		end
	end

`ifndef ASSERT_OFF
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("missed ray carries a non-zero result");

	a_t_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && hit_s7 |-> (t_s7 > $signed(side_s7.tn)) && (t_s7 < $signed(side_s7.tf)))
		else $error("hit distance outside the ray window");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s7) && $stable(t_s7))
		else $error("pipeline moved during a stall");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray oriented box testbench
// Streams rays through the box test under several box settings. A directed
// table covers reset geometry, extreme fields, zero directions, empty slabs
// and window cases; random rays follow. Every result word is compared with a
// bit-accurate local prediction of the slab test, while both stream sides
// idle at random except in one quiet phase of the random rays.
// ----------------------------------------------------------------------------
module testbench;
	import rob_pkg::*;

	typedef struct packed {
		logic [31:0] tf;
		logic [31:0] tn;
		logic [31:0] dz;
		logic [31:0] dy;
		logic [31:0] dx;
		logic [31:0] oz;
		logic [31:0] oy;
		logic [31:0] ox;
	} ray_t;

	typedef struct {
		logic         hit;
		logic [191:0] data;
	} hit_rec_t;

	typedef struct {
		ray_t         ray;
		logic         known;
		logic         hit;
		logic [191:0] data;
	} row_t;

	localparam longint BIAS_START = 64'sd655360000000000;
	localparam longint SAT46      = 64'sd70368744177664;
	localparam int     LATENCY    = 67;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [191:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;

	logic [63:0] box_center_xy;
	logic [31:0] box_center_z;
	logic [63:0] box_half_xy;
	logic [30:0] box_half_z;
	logic [59:0] box_rot [3];

	hit_rec_t expected_hits[$];
	int       errors;
	bit       quiet_src;
	bit       quiet_snk;
	row_t     rows[$];

	ray_oriented_box_intersect u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

	function automatic longint rot_at(int r, int c);
		logic signed [19:0] e;
		e = box_rot[r][20*c +: 20];
		return longint'(e);
	endfunction

	function automatic longint mul_floor_sat(longint t, longint d);
		longint unsigned at, ad, mag;
		bit neg;
		at = t < 0 ? -t : t;
		ad = d < 0 ? -d : d;
		neg = (t < 0) != (d < 0);
		if (at != 0 && ad > (64'h4000000000000000 / at))
			return neg ? -SAT46 : SAT46;
		mag = at * ad;
		if (mag > 64'h4000000000000000)
			return neg ? -SAT46 : SAT46;
		return (neg ? -longint'(mag) : longint'(mag)) >>> 16;
	endfunction

	function automatic hit_rec_t box_hit(ray_t ray);
		hit_rec_t res;
		longint org[3], dir[3], cen[3], hx[3], ol[3], dl[3];
		longint tn, tf, tmin, tmax, t, bias, so, sd, lo, hi, ta, tb, p, bl, bh, n, w;
		bit miss;
		int face;
		res.hit = 1'b0;
		res.data = '0;
		org[0] = longint'(signed'(ray.ox));
		org[1] = longint'(signed'(ray.oy));
		org[2] = longint'(signed'(ray.oz));
		dir[0] = longint'(signed'(ray.dx));
		dir[1] = longint'(signed'(ray.dy));
		dir[2] = longint'(signed'(ray.dz));
		tn = longint'(signed'(ray.tn));
		tf = longint'(signed'(ray.tf));
		cen[0] = longint'(signed'(box_center_xy[31:0]));
		cen[1] = longint'(signed'(box_center_xy[63:32]));
		cen[2] = longint'(signed'(box_center_z));
		hx[0] = longint'(box_half_xy[31:0]);
		hx[1] = longint'(box_half_xy[63:32]);
		hx[2] = longint'(box_half_z);
		tmin = tn;
		tmax = tf;
		miss = 0;
		face = 0;
		bias = BIAS_START;
		for (int i = 0; i < 3; i++) begin
			so = 0;
			sd = 0;
			for (int r = 0; r < 3; r++) begin
				so += rot_at(r, i) * (org[r] - cen[r]);
				sd += rot_at(r, i) * dir[r];
			end
			ol[i] = so >>> 18;
			dl[i] = sd >>> 18;
		end
		for (int i = 0; i < 3; i++) begin
			lo = -hx[i] - ol[i];
			hi = hx[i] - ol[i];
			if (dl[i] == 0) begin
				if (lo > 0 || hi < 0)
					miss = 1;
			end else begin
				ta = (lo * 65536) / dl[i];
				tb = (hi * 65536) / dl[i];
				if (dl[i] < 0) begin
					w = ta;
					ta = tb;
					tb = w;
				end
				if (ta > tmin)
					tmin = ta;
				if (tb < tmax)
					tmax = tb;
			end
		end
		if (miss || tmin > tmax)
			return res;
		if (tmin > tn && tmin < tf)
			t = tmin;
		else if (tmax > tn && tmax < tf)
			t = tmax;
		else
			return res;
		for (int i = 0; i < 3; i++) begin
			p = ol[i] + mul_floor_sat(t, dl[i]);
			bl = -hx[i] - p;
			bl = bl < 0 ? -bl : bl;
			bh = hx[i] - p;
			bh = bh < 0 ? -bh : bh;
			if (bl < bias) begin
				bias = bl;
				face = 2 * i;
			end
			if (bh < bias) begin
				bias = bh;
				face = 2 * i + 1;
			end
		end
		res.hit = 1'b1;
		res.data[31:0] = t[31:0];
		for (int r = 0; r < 3; r++) begin
			n = rot_at(r, face / 2);
			if (!face[0])
				n = -n;
			if (n > 524287)
				n = 524287;
			res.data[32 + 20*r +: 20] = n[19:0];
			p = ((t * dir[r]) >>> 16) + org[r];
			if (p > 64'sd2147483647)
				p = 64'sd2147483647;
			if (p < -64'sd2147483648)
				p = -64'sd2147483648;
			res.data[92 + 32*r +: 32] = p[31:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [191:0] got, logic [191:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CENTER_XY:      box_center_xy = val;
			CFG_CENTER_Z:       box_center_z = val[31:0];
			CFG_HALF_EXTENT_XY: box_half_xy = val;
			CFG_HALF_EXTENT_Z:  box_half_z = val[30:0];
			CFG_ROT_ROW0:       box_rot[0] = val[59:0];
			CFG_ROT_ROW1:       box_rot[1] = val[59:0];
			CFG_ROT_ROW2:       box_rot[2] = val[59:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_ray(ray_t ray, bit known, logic hit, logic [191:0] data);
		hit_rec_t h;
		while (!quiet_src && $urandom_range(99) < 23) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ray;
		do
			@(posedge clk);
		while (!s_axis_tready);
		h = box_hit(ray);
		if (known) begin
			if (h.hit !== hit || h.data !== data)
				report_mismatch("table", {h.hit, h.data[190:0]}, {hit, data[190:0]});
			h.hit = hit;
			h.data = data;
		end
		expected_hits.push_back(h);
	endtask

	task automatic drain;
		int guard;
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (expected_hits.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
			default: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
		endcase
	endfunction

	function automatic ray_t rand_ray();
		ray_t r;
		int m;
		m = $urandom_range(9);
		r.ox = rand_coord(m < 1 ? 0 : 2);
		r.oy = rand_coord(m < 1 ? 0 : 2);
		r.oz = rand_coord(m < 1 ? 0 : 2);
		r.dx = (m == 2) ? '0 : rand_coord(m < 1 ? 0 : 1);
		r.dy = (m == 3) ? '0 : rand_coord(m < 1 ? 0 : 1);
		r.dz = rand_coord(m < 1 ? 0 : 1);
		if (m > 4) begin
			// aim roughly at the box centre so that many rays hit
			r.dx = box_center_xy[31:0] - r.ox;
			r.dy = box_center_xy[63:32] - r.oy;
			r.dz = box_center_z - r.oz;
			r.dx = $signed(r.dx) >>> 3;
			r.dy = $signed(r.dy) >>> 3;
			r.dz = $signed(r.dz) >>> 3;
		end
		r.tn = (m < 1) ? $urandom : 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
		r.tf = (m < 1) ? $urandom : $urandom_range(0, 32'h7fff_ffff);
		return r;
	endfunction

	function automatic logic [59:0] rand_rot_row();
		logic [59:0] v;
		for (int c = 0; c < 3; c++)
			v[20*c +: 20] = ($urandom_range(3) == 0) ? 20'($urandom) :
				20'($signed($urandom_range(0, 20'h80000)) - 20'sh40000);
		return v;
	endfunction

	function automatic ray_t mk(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
		logic [31:0] dx, logic [31:0] dy, logic [31:0] dz, logic [31:0] tn, logic [31:0] tf);
		ray_t r;
		r = '{tf: tf, tn: tn, dz: dz, dy: dy, dx: dx, oz: oz, oy: oy, ox: ox};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet_snk || ($urandom_range(99) >= 23);
		end
	end

	always @(posedge clk) begin
		hit_rec_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata, '0);
			end else begin
				want = expected_hits.pop_front();
				if (m_axis_tuser !== want.hit)
					report_mismatch("hit", 192'(m_axis_tuser), 192'(want.hit));
				if (m_axis_tdata[31:0] !== want.data[31:0])
					report_mismatch("hit_t", 192'(m_axis_tdata[31:0]), 192'(want.data[31:0]));
				for (int k = 0; k < 3; k++) begin
					if (m_axis_tdata[32 + 20*k +: 20] !== want.data[32 + 20*k +: 20])
						report_mismatch("normal", 192'(m_axis_tdata[32 + 20*k +: 20]),
							192'(want.data[32 + 20*k +: 20]));
					if (m_axis_tdata[92 + 32*k +: 32] !== want.data[92 + 32*k +: 32])
						report_mismatch("point", 192'(m_axis_tdata[92 + 32*k +: 32]),
							192'(want.data[92 + 32*k +: 32]));
				end
				if (m_axis_tdata[191:188] !== 4'd0)
					report_mismatch("pad", 192'(m_axis_tdata[191:188]), '0);
			end
		end
	end

	initial begin
		row_t rw;
		logic [191:0] one_hit;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CENTER_XY;
		cfg_data = '0;
		errors = 0;
		quiet_src = 0;
		quiet_snk = 0;
		box_center_xy = '0;
		box_center_z = '0;
		box_half_xy = 64'h0000_8000_0000_8000;
		box_half_z = 31'h8000;
		box_rot[0] = 60'h40000;
		box_rot[1] = 60'h40000 << 20;
		box_rot[2] = 60'h40000 << 40;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// along +x from x = -2 with unit direction: enters the -x face at t = 1.5
		one_hit = '0;
		one_hit[31:0] = 32'h0001_8000;
		one_hit[51:32] = 20'hc0000;
		one_hit[123:92] = 32'hffff_8000;
		rows.push_back('{mk(32'hfffe_0000, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0010_0000),
			1, 1, one_hit});
		// zero direction outside the slab misses
		rows.push_back('{mk(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 32'h8000_0000,
			32'h7fff_ffff), 1, 0, '0});
		// window closes before the box
		rows.push_back('{mk(32'hfffe_0000, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000),
			1, 0, '0});
		// empty slab: ray passes beside the box
		rows.push_back('{mk(32'hfffe_0000, 32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0,
			32'h0010_0000), 1, 0, '0});
		// all-zero and all-ones rays
		rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0});
		rows.push_back('{mk('1, '1, '1, '1, '1, '1, '1, '1), 0, 0, '0});
		rows.push_back('{mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), 0, 0, '0});
		rows.push_back('{mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff), 0, 0, '0});
		// inside the box with the window opening behind it: entry distance reported
		rows.push_back('{mk(0, 0, 0, 0, 32'hffff_0000, 0, 32'hffff_0000, 32'h0010_0000),
			0, 0, '0});
		// diagonal corner tie
		rows.push_back('{mk(32'hfffe_0000, 32'hfffe_0000, 0, 32'h0001_0000, 32'h0001_0000,
			0, 0, 32'h0010_0000), 0, 0, '0});
		rows.push_back('{mk(0, 0, 32'h0004_0000, 0, 0, 32'hffff_0000, 32'h8000_0000,
			32'h7fff_ffff), 0, 0, '0});
		rows.push_back('{mk(0, 0, 32'h0000_8000, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff),
			0, 0, '0});
		foreach (rows[i]) begin
			rw = rows[i];
			send_ray(rw.ray, rw.known, rw.hit, rw.data);
		end
		drain();

		// a negated -2 rotation entry must saturate; extremes of the centre and half-extent registers
		write_reg(CFG_ROT_ROW0, 64'(60'h80000));
		write_reg(CFG_HALF_EXTENT_Z, 64'(31'h7fff_ffff));
		write_reg(CFG_HALF_EXTENT_XY, 64'hffff_ffff_ffff_ffff);
		write_reg(CFG_CENTER_XY, 64'h8000_0000_7fff_ffff);
		write_reg(CFG_CENTER_Z, 64'(32'h8000_0000));
		rows.delete();
		foreach (rows[i]) ;
		for (int i = 0; i < 8; i++) begin
			send_ray(mk(32'hfffe_0000 ^ (i << 30), 0, 32'h8000_0000, 32'h0001_0000,
				i[0] ? 32'h0001_0000 : 0, i[1] ? 32'hffff_0000 : 32'h0001_0000,
				32'h8000_0000, 32'h7fff_ffff), 0, 0, '0);
		end
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 7) begin
				write_reg(CFG_CENTER_XY, '0);
				write_reg(CFG_CENTER_Z, '0);
				write_reg(CFG_HALF_EXTENT_XY, '0);
				write_reg(CFG_HALF_EXTENT_Z, '0);
				write_reg(CFG_ROT_ROW0, '1);
				write_reg(CFG_ROT_ROW1, '0);
				write_reg(CFG_ROT_ROW2, '1);
			end else begin
				write_reg(CFG_CENTER_XY, {$urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
					$urandom_range(0, 32'h0008_0000) - 32'h0004_0000});
				write_reg(CFG_CENTER_Z,
					64'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000));
				write_reg(CFG_HALF_EXTENT_XY, {32'($urandom_range(0, 32'h0004_0000)),
					32'($urandom_range(0, 32'h0004_0000))});
				write_reg(CFG_HALF_EXTENT_Z, 64'($urandom_range(0, 32'h0004_0000)));
				write_reg(CFG_ROT_ROW0, 64'(rand_rot_row()));
				write_reg(CFG_ROT_ROW1, 64'(rand_rot_row()));
				write_reg(CFG_ROT_ROW2, 64'(rand_rot_row()));
			end
			quiet_src = (phase == 3);
			quiet_snk = (phase == 3);
			for (int i = 0; i < 100; i++)
				send_ray(rand_ray(), 0, 0, '0);
			drain();
		end

		if (expected_hits.size() != 0)
			errors++;
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/rob_pkg.sv
hw/rtl/rob_div.sv
hw/rtl/ray_oriented_box_intersect.sv
verif/testbench.sv
